@@ src/assert_macros.svh @@
// Assertion shorthands shared by the RTL. Every macro samples on the rising
// edge of clk and is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/btm3_pkg.sv @@
package btm3_pkg;

  // Configuration register widths
  localparam int TMPL_W     = 9;
  localparam int IMG_W_W    = 7;
  localparam int IMG_H_W    = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [TMPL_W-1:0]     tmpl_t;
  typedef logic [IMG_W_W-1:0]    img_width_t;
  typedef logic [IMG_H_W-1:0]    img_height_t;

  // Register indexes on the configuration port
  localparam cfg_idx_t REG_TEMPLATE = 2'd0;
  localparam cfg_idx_t REG_WIDTH    = 2'd1;
  localparam cfg_idx_t REG_HEIGHT   = 2'd2;

  // Register values after reset
  localparam tmpl_t       TMPL_RESET   = 9'd186;
  localparam img_width_t  WIDTH_RESET  = 7'd6;
  localparam img_height_t HEIGHT_RESET = 13'd8;

  // Line store entry: bit 0 is the pixel one row up, bit 1 the pixel two rows up.
  typedef logic [1:0] line_t;

  // Shift the 3x3 window one column left and insert the new column at
  // column 2. Bit r*3+c holds row r, column c; row 0 is the top row.
  function automatic tmpl_t shift_window(tmpl_t w, logic top, logic mid, logic bot);
    tmpl_t out;
    out    = '0;
    out[0] = w[1];
    out[1] = w[2];
    out[2] = top;
    out[3] = w[4];
    out[4] = w[5];
    out[5] = mid;
    out[6] = w[7];
    out[7] = w[8];
    out[8] = bot;
    return out;
  endfunction

endpackage

@@ src/binary_template_match_3x3_top.sv @@
// An accepted beat passes stage one and the result register before it reaches m_tdata.
// Throughput: one pixel per clock unless m_tready stalls; line store read in the first
// stage, window update and template compare in the second, with a line store bypass.
// Reset (rst, synchronous, active high) empties both stages, zeros the position counters
// and window, and loads the registers with template 186, width 6 and height 8.
// The line store is not cleared; only entries written in the current frame reach a result.
`include "assert_macros.svh"

module binary_template_match_3x3_top #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 4096,
  localparam int COL_W       = $clog2(MAX_WIDTH),
  localparam int ROW_W       = $clog2(MAX_HEIGHT),
  localparam int OUT_FIELD_W = 2 + ROW_W + COL_W,
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  // Input pixel stream
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [7:0]               s_tdata,   // [0] pixel, [7:1] zero fill
  input  logic                     s_tuser,   // [0] start_frame
  // Result stream
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_W-1:0]    m_tdata,   // window_full, center_match, center_row,
                                              // center_col, zero fill
  // Configuration write port
  input  logic                     cfg_wr_en,
  input  btm3_pkg::cfg_idx_t       cfg_addr,
  input  btm3_pkg::cfg_data_t      cfg_wdata
);

  import btm3_pkg::*;

  localparam int W_CMP_W = (COL_W + 1 > IMG_W_W) ? COL_W + 1 : IMG_W_W;
  localparam int H_CMP_W = (ROW_W + 1 > IMG_H_W) ? ROW_W + 1 : IMG_H_W;

  // Configuration registers
  tmpl_t       template_bits;
  img_width_t  image_width;
  img_height_t image_height;

  // Position of the next pixel
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;

  // First stage: pixel and position while the line store is read
  logic             s1_valid;
  logic             s1_pixel;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;
  logic             s1_fwd;
  line_t            s1_fwd_data;

  // Window and result register
  tmpl_t            window;
  logic             out_full;
  logic             out_match;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;

  logic             in_accept;
  logic             s1_advance;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [W_CMP_W-1:0] col_inc;
  logic [H_CMP_W-1:0] row_inc;
  logic             col_wrap;
  logic             row_wrap;
  line_t            ram_rdata;
  line_t            stored;
  line_t            line_wdata;
  tmpl_t            window_next;
  logic             full;
  logic             match;

  // Handshake: stage one moves on whenever the result register is free
  assign s1_advance = s1_valid && (!m_tvalid || m_tready);
  assign s_tready   = !s1_valid || s1_advance;
  assign in_accept  = s_tvalid && s_tready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      template_bits <= TMPL_RESET;
      image_width   <= WIDTH_RESET;
      image_height  <= HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_TEMPLATE: template_bits <= cfg_wdata[TMPL_W-1:0];
        REG_WIDTH:    image_width   <= cfg_wdata[IMG_W_W-1:0];
        REG_HEIGHT:   image_height  <= cfg_wdata[IMG_H_W-1:0];
        default:      ;
      endcase
    end
  end

  // Position of the incoming pixel and the wrap of both counters
  always_comb begin
    cur_col  = s_tuser ? '0 : col_count;
    cur_row  = s_tuser ? '0 : row_count;
    col_inc  = W_CMP_W'(cur_col) + W_CMP_W'(1);
    row_inc  = H_CMP_W'(cur_row) + H_CMP_W'(1);
    col_wrap = (col_inc >= W_CMP_W'(image_width)) || (col_inc >= W_CMP_W'(MAX_WIDTH));
    row_wrap = (row_inc >= H_CMP_W'(image_height)) || (row_inc >= H_CMP_W'(MAX_HEIGHT));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_accept) begin
      if (col_wrap) begin
        col_count <= '0;
        row_count <= row_wrap ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_count <= col_inc[COL_W-1:0];
        row_count <= cur_row;
      end
    end
  end

  // Line store: read when a pixel enters, written back when it leaves stage one
  btm3_ram #(
    .WIDTH ($bits(line_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (s1_advance),
    .wr_addr (s1_col),
    .wr_data (line_wdata),
    .rd_en   (in_accept),
    .rd_addr (cur_col),
    .rd_data (ram_rdata)
  );

  // Stage one; the bypass catches a write to the column being read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pixel    <= s_tdata[0];
      s1_col      <= cur_col;
      s1_row      <= cur_row;
      s1_fwd      <= s1_advance && (s1_col == cur_col);
      s1_fwd_data <= line_wdata;
    end
  end

  // Window update and template compare
  always_comb begin
    stored      = s1_fwd ? s1_fwd_data : ram_rdata;
    line_wdata  = {stored[0], s1_pixel};
    window_next = shift_window(window, stored[1], stored[0], s1_pixel);
    full        = (s1_row >= ROW_W'(2)) && (s1_col >= COL_W'(2));
    match       = full && (window_next == template_bits);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (s1_advance) begin
      window <= window_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_full  <= full;
      out_match <= match;
      out_row   <= full ? s1_row - ROW_W'(1) : '0;
      out_col   <= full ? s1_col - COL_W'(1) : '0;
    end
  end

  assign m_tdata = OUT_DATA_W'({out_col, out_row, out_match, out_full});

  // Checks
  `ASSERT_IMPLIES(a_match_needs_full, m_tvalid && out_match, out_full, "match outside a full window")
  `ASSERT_IMPLIES(a_border_zero, m_tvalid && !out_full, out_row == '0 && out_col == '0, "border result has nonzero position")
  `ASSERT_ALWAYS(a_col_in_range, 32'(col_count) < MAX_WIDTH, "column counter past line store depth")
  `ASSERT_NEXT(a_accept_fills_s1, in_accept, s1_valid, "accepted pixel lost before stage one")

endmodule

@@ src/btm3_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
module btm3_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
